FILE: rtl/i2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg - shared types and constants for the integer to ASCII formatter
// Format opcodes, sequencer states, digit sizing and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package i2a_pkg;

   localparam int VALUE_BITS   = 64;
   // decimal digits needed for 2^VALUE_BITS - 1 (log10(2) ~ 0.301)
   localparam int DEC_DIGITS   = (VALUE_BITS * 301) / 1000 + 1;
   localparam int HEX_DIGITS   = (VALUE_BITS + 3) / 4;
   localparam int HEX32_DIGITS = 8;
   localparam int DIG_W        = DEC_DIGITS * 4;
   localparam int HEX_W        = HEX_DIGITS * 4;
   localparam int CNT_W        = $clog2(DEC_DIGITS + 1);
   localparam int BIT_W        = $clog2(VALUE_BITS);

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_A     = 7'h61;
   localparam logic [6:0] CHAR_MINUS = 7'h2d;
   localparam logic [6:0] CHAR_X     = 7'h78;

   typedef enum logic [2:0] {
      OP_UDEC  = 3'd0,
      OP_SDEC  = 3'd1,
      OP_HEX   = 3'd2,
      OP_HEX32 = 3'd3,
      OP_HEX64 = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_ZERO,
      ST_XCHR,
      ST_DIGS
   } state_type;

   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {3'b000, d};
      end else begin
         c = CHAR_A + {3'b000, d} - 7'd10;
      end
      return c;
   endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter - 64-bit integer to ASCII character stream
// Decimal (unsigned/signed) and hex (plain, 0x+8, 0x+16) formatting.
// ----------------------------------------------------------------------------
// One value is taken per run and the block is busy until its last character
// has been loaded into the output register. Decimal formats convert through a
// shift-and-add-3 loop, one value bit per cycle, then skip leading zeros and
// emit the remaining characters; skipped zeros and digits always add up to 20.
// The output register lets the next value be taken while the last character
// of the previous one is still waiting. Opcodes 5..7 are dropped with no
// output.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value,
   input  logic [2:0]  req_opcode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_last
);

   localparam int VB    = i2a_pkg::VALUE_BITS;
   localparam int DW    = i2a_pkg::DIG_W;
   localparam int HW    = i2a_pkg::HEX_W;
   localparam int CW    = i2a_pkg::CNT_W;
   localparam int BW    = i2a_pkg::BIT_W;

   i2a_pkg::state_type state_ff, state_in;

   logic [VB-1:0] bin_ff, bin_in;
   logic [DW-1:0] dig_ff, dig_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic          neg_ff, neg_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [VB-1:0] val_w;
   logic [VB-1:0] mag_w;
   logic          neg_w;
   logic [DW-1:0] adj_w;
   logic [3:0]    top_w;
   logic          out_free;
   logic          more_zero;

   assign val_w     = req_value[VB-1:0];
   assign neg_w     = (req_opcode == i2a_pkg::OP_SDEC) && val_w[VB-1];
   assign mag_w     = neg_w ? VB'(~val_w + 1'b1) : val_w;
   assign top_w     = dig_ff[DW-1 -: 4];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign more_zero = (cnt_ff > CW'(1)) && (top_w == 4'h0);

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
         adj_w[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? dig_ff[i*4 +: 4] + 4'd3
                                                      : dig_ff[i*4 +: 4];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  i2a_pkg::OP_UDEC,
                  i2a_pkg::OP_SDEC:  state_in = i2a_pkg::ST_CONV;
                  i2a_pkg::OP_HEX:   state_in = i2a_pkg::ST_SKIP;
                  i2a_pkg::OP_HEX32,
                  i2a_pkg::OP_HEX64: state_in = i2a_pkg::ST_ZERO;
                  default:           state_in = i2a_pkg::ST_IDLE;
               endcase
            end
         end
         i2a_pkg::ST_CONV: begin
            if (bit_ff == '0) state_in = i2a_pkg::ST_SKIP;
         end
         i2a_pkg::ST_SKIP: begin
            if (!more_zero) state_in = neg_ff ? i2a_pkg::ST_SIGN : i2a_pkg::ST_DIGS;
         end
         i2a_pkg::ST_SIGN: begin
            if (out_free) state_in = i2a_pkg::ST_DIGS;
         end
         i2a_pkg::ST_ZERO: begin
            if (out_free) state_in = i2a_pkg::ST_XCHR;
         end
         i2a_pkg::ST_XCHR: begin
            if (out_free) state_in = i2a_pkg::ST_DIGS;
         end
         i2a_pkg::ST_DIGS: begin
            if (out_free && cnt_ff == CW'(1)) state_in = i2a_pkg::ST_IDLE;
         end
         default: state_in = i2a_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      bin_in       = bin_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      neg_in       = neg_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bin_in = mag_w;
               bit_in = BW'(VB - 1);
               neg_in = neg_w;
               case (req_opcode)
                  i2a_pkg::OP_HEX: begin
                     dig_in = {HW'(val_w), {(DW - HW){1'b0}}};
                     cnt_in = CW'(i2a_pkg::HEX_DIGITS);
                  end
                  i2a_pkg::OP_HEX32: begin
                     dig_in = {val_w[31:0], {(DW - 32){1'b0}}};
                     cnt_in = CW'(i2a_pkg::HEX32_DIGITS);
                  end
                  i2a_pkg::OP_HEX64: begin
                     dig_in = {HW'(val_w), {(DW - HW){1'b0}}};
                     cnt_in = CW'(i2a_pkg::HEX_DIGITS);
                  end
                  default: begin
                     dig_in = '0;
                     cnt_in = CW'(i2a_pkg::DEC_DIGITS);
                  end
               endcase
            end
         end
         i2a_pkg::ST_CONV: begin
            dig_in = {adj_w[DW-2:0], bin_ff[VB-1]};
            bin_in = {bin_ff[VB-2:0], 1'b0};
            bit_in = bit_ff - 1'b1;
         end
         i2a_pkg::ST_SKIP: begin
            if (more_zero) begin
               dig_in = {dig_ff[DW-5:0], 4'h0};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         i2a_pkg::ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = i2a_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         i2a_pkg::ST_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = i2a_pkg::CHAR_ZERO;
               rsp_last_in  = 1'b0;
            end
         end
         i2a_pkg::ST_XCHR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = i2a_pkg::CHAR_X;
               rsp_last_in  = 1'b0;
            end
         end
         i2a_pkg::ST_DIGS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = i2a_pkg::digit_char(top_w);
               rsp_last_in  = (cnt_ff == CW'(1));
               dig_in       = {dig_ff[DW-5:0], 4'h0};
               cnt_in       = cnt_ff - 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      dig_ff      <= dig_in;
      cnt_ff      <= cnt_in;
      bit_ff      <= bit_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: tb/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter - character stream check of the formatter
// Drives values and format opcodes through a valid/ready driver, predicts the
// ASCII text of each accepted value and compares every response beat, code
// and last flag, against it in order. Runs with and without idle/stall gaps.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;

   localparam int          MAX_CHARS      = 20;
   localparam int          RANDOM_ITEMS   = 47;   // per phase
   localparam int          NUM_PHASES     = 4;
   localparam int          DRAIN_CYCLES   = 150;
   localparam longint      TIMEOUT_NS     = 64'd5_000_000;

   // opcodes the block drops without output
   localparam logic [2:0]  OP_RSVD_5 = 3'd5;
   localparam logic [2:0]  OP_RSVD_6 = 3'd6;
   localparam logic [2:0]  OP_RSVD_7 = 3'd7;

   localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] MOST_NEG  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS  = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] TEN_POW19 = 64'd10_000_000_000_000_000_000;

   typedef struct {
      logic [63:0] value;
      logic [2:0]  opcode;
   } format_req_type;

   typedef struct {
      logic [6:0] code;
      logic       last;
   } char_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value = '0;
   logic [2:0]  req_opcode = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_char_code;
   logic        rsp_last;

   format_req_type value_queue [$];
   char_beat_type  expected_chars [$];
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             error_count = 0;
   int             chars_checked = 0;
   format_req_type next_req;
   char_beat_type  want;

   integer_to_ascii_formatter u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_opcode    (req_opcode),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic [6:0] nibble_to_ascii(input logic [3:0] d);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = i2a_pkg::CHAR_ZERO + 7'(d);
      end else begin
         c = i2a_pkg::CHAR_A + 7'(d) - 7'd10;
      end
      return c;
   endfunction

   // Expected text of one accepted value, queued as response beats.
   function automatic void format_value(input logic [63:0] value, input logic [2:0] op);
      logic [i2a_pkg::VALUE_BITS-1:0] mag;
      logic [i2a_pkg::VALUE_BITS-1:0] radix;
      logic [i2a_pkg::VALUE_BITS-1:0] rem;
      logic [6:0]                     digits [$];
      logic [6:0]                     text [$];
      int                             ndig;
      char_beat_type                  beat;
      mag = value[i2a_pkg::VALUE_BITS-1:0];
      case (op)
         i2a_pkg::OP_UDEC, i2a_pkg::OP_SDEC, i2a_pkg::OP_HEX: begin
            if (op == i2a_pkg::OP_SDEC && mag[i2a_pkg::VALUE_BITS-1]) begin
               text.push_back(i2a_pkg::CHAR_MINUS);
               mag = -mag;
            end
            radix = (op == i2a_pkg::OP_HEX) ? i2a_pkg::VALUE_BITS'(16)
                                            : i2a_pkg::VALUE_BITS'(10);
            if (mag == '0) begin
               digits.push_front(i2a_pkg::CHAR_ZERO);
            end
            while (mag != '0) begin
               rem = mag % radix;
               digits.push_front(nibble_to_ascii(rem[3:0]));
               mag = mag / radix;
            end
            foreach (digits[i]) text.push_back(digits[i]);
         end
         i2a_pkg::OP_HEX32, i2a_pkg::OP_HEX64: begin
            ndig = (op == i2a_pkg::OP_HEX32) ? i2a_pkg::HEX32_DIGITS
                                             : i2a_pkg::HEX_DIGITS;
            text.push_back(i2a_pkg::CHAR_ZERO);
            text.push_back(i2a_pkg::CHAR_X);
            for (int i = ndig - 1; i >= 0; i--) begin
               rem = mag >> (i * 4);
               text.push_back(nibble_to_ascii(rem[3:0]));
            end
         end
         default: begin
            // unused opcode: no text at all
         end
      endcase
      while (text.size() > MAX_CHARS) text.pop_back();
      foreach (text[i]) begin
         beat.code = text[i];
         beat.last = (i == text.size() - 1);
         expected_chars.push_back(beat);
      end
   endfunction

   task automatic add_item(input logic [63:0] value, input logic [2:0] op);
      format_req_type r;
      r.value  = value;
      r.opcode = op;
      value_queue.push_back(r);
   endtask

   task automatic add_random_item();
      logic [63:0] v;
      logic [63:0] tens;
      case ($urandom_range(0, 7))
         0: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         1: v = 64'($urandom_range(0, 999));
         2: begin
            tens = 64'd1;
            repeat ($urandom_range(0, 19)) tens = tens * 10;
            v = tens + 64'($urandom_range(0, 2)) - 64'd1;
         end
         3: v = -64'($urandom_range(1, 1000));
         4: begin
            case ($urandom_range(0, 6))
               0: v = '0;
               1: v = 64'd1;
               2: v = ALL_ONES;
               3: v = MOST_NEG;
               4: v = MOST_POS;
               5: v = 64'h0000_0000_ffff_ffff;
               default: v = 64'h0000_0001_0000_0000;
            endcase
         end
         default: v = {$urandom, $urandom};
      endcase
      add_item(v, 3'($urandom_range(i2a_pkg::OP_UDEC, i2a_pkg::OP_HEX64)));
      // dropped opcodes now and then, on top of the real items
      if ($urandom_range(0, 9) == 0) begin
         add_item({$urandom, $urandom}, 3'($urandom_range(OP_RSVD_5, OP_RSVD_7)));
      end
   endtask

   // request driver: predicts on every accepted beat, holds valid until taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            format_value(req_value, req_opcode);
         end
         if (!req_valid || req_ready) begin
            if (value_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_req = value_queue.pop_front();
               req_valid  <= 1'b1;
               req_value  <= next_req.value;
               req_opcode <= next_req.opcode;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected beat char 0x%02h last %0b",
                                         rsp_char_code, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.code) begin
                  report_mismatch($sformatf("beat %0d char 0x%02h, expected 0x%02h",
                                            chars_checked, rsp_char_code, want.code));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("beat %0d last %0b, expected %0b",
                                            chars_checked, rsp_last, want.last));
               end
            end
            chars_checked++;
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         if (phase == 0) begin
            add_item(64'd0, i2a_pkg::OP_UDEC);
            add_item(64'd9, i2a_pkg::OP_UDEC);
            add_item(64'd10, i2a_pkg::OP_UDEC);
            add_item(ALL_ONES, i2a_pkg::OP_UDEC);
            add_item(TEN_POW19, i2a_pkg::OP_UDEC);
            add_item(64'd0, i2a_pkg::OP_SDEC);
            add_item(64'd1, i2a_pkg::OP_SDEC);
            add_item(ALL_ONES, i2a_pkg::OP_SDEC);
            add_item(MOST_NEG, i2a_pkg::OP_SDEC);        // magnitude has no positive twin
            add_item(MOST_POS, i2a_pkg::OP_SDEC);
            add_item(-64'd10, i2a_pkg::OP_SDEC);
            add_item(64'd0, i2a_pkg::OP_HEX);
            add_item(64'd1, i2a_pkg::OP_HEX);
            add_item(ALL_ONES, i2a_pkg::OP_HEX);
            add_item(64'hfedc_ba98_7654_3210, i2a_pkg::OP_HEX);
            add_item(64'd0, i2a_pkg::OP_HEX32);
            add_item(64'hdead_beef_0a1b_2c3d, i2a_pkg::OP_HEX32);  // upper word ignored
            add_item(ALL_ONES, i2a_pkg::OP_HEX32);
            add_item(64'd0, i2a_pkg::OP_HEX64);
            add_item(ALL_ONES, i2a_pkg::OP_HEX64);
            add_item(64'h0123_4567_89ab_cdef, i2a_pkg::OP_HEX64);
            add_item(ALL_ONES, OP_RSVD_5);
            add_item(64'd0, OP_RSVD_6);
            add_item(MOST_NEG, OP_RSVD_7);
         end
         repeat (RANDOM_ITEMS) add_random_item();
         while (value_queue.size() != 0 || req_valid) @(posedge clock);
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (expected_chars.size() != 0) @(posedge clock);
      // catch any stray beats from late or dropped items
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
